/* design/edge_trigger_with_cooldown_assert.svh */
// assertion macros for the edge trigger with cooldown block
`ifndef EDGE_TRIGGER_WITH_COOLDOWN_ASSERT_SVH
`define EDGE_TRIGGER_WITH_COOLDOWN_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ETC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// expression must never be true outside reset
`define ETC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define ETC_ASSERT(label, clk, rst_n, prop, msg)
`define ETC_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

/* design/etc_pkg.sv */
`default_nettype none

package etc_pkg;

    localparam logic [13:0] FULL_SCALE   = 14'd10000;
    localparam int unsigned SYMBOL_COUNT = 256;
    localparam int unsigned ADDR_W       = 5;

    // register reset values
    localparam logic [13:0] THRESHOLD_RST = 14'd5000;
    localparam logic [15:0] COOLDOWN_RST  = 16'd1000;
    localparam logic [15:0] GRACE_RST     = 16'd500;

    typedef enum logic [2:0] {
        REG_DETECT_MODE = 3'd0,
        REG_THRESHOLD   = 3'd1,
        REG_FIRE_ABOVE  = 3'd2,
        REG_COOLDOWN_MS = 3'd3,
        REG_WM_ENABLE   = 3'd4,
        REG_GRACE_MS    = 3'd5
    } reg_idx_t;

    typedef enum logic {
        MODE_LEVEL  = 1'b0,
        MODE_SYMBOL = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_EVAL  = 2'd0,
        ST_HELD  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] elapsed_ms;
        logic        measure_ok;
        logic [13:0] level;
        logic [7:0]  symbol_index;
        logic        clear_watermark;
    } in_item_t;

    typedef struct packed {
        logic        fired;
        logic        latched;
        logic [13:0] reported_level;
        logic [7:0]  reported_symbol;
        logic        reported_symbol_valid;
        logic [15:0] cooldown_left_ms;
        status_t     status;
    } out_item_t;

    typedef struct packed {
        mode_t       detect_mode;
        logic [13:0] threshold;
        logic        fire_above;
        logic [15:0] cooldown_ms;
        logic        wm_enable;
        logic [15:0] grace_ms;
    } cfg_t;

    typedef struct packed {
        logic [15:0] cooldown_left;
        logic        fire_latch;
        logic [7:0]  sent_symbol;
        logic        sent_symbol_valid;
        logic [13:0] held_level;
        logic [13:0] low_mark;
        logic [13:0] pending_low;
        logic        pending_active;
        logic [15:0] pending_age;
    } st_t;

endpackage

`default_nettype wire

/* design/edge_trigger_with_cooldown.sv */
`default_nettype none
`include "edge_trigger_with_cooldown_assert.svh"

// Edge trigger with cooldown, one detector channel. Each transfer on the
// item channel carries one measured level with its elapsed time, validity
// flag and symbol index, and produces exactly one transfer on the result
// channel. The block sustains one item per clock cycle while results are
// taken; a result is offered once its item has passed the input register
// and then the result register. That rate is set by the combinational
// update of the channel state (cooldown, fire latch, sent symbol, low
// watermark), which every item reads and rewrites. While a finished
// result waits to be taken, the input register holds one more item and
// then the item channel stalls until the result drains. Registers sit on
// an APB-style port at byte address 4*index: detect mode, threshold,
// fire above, cooldown, watermark enable and grace; write them only while
// no item is in flight. pready is tied high, so every access completes
// without wait states.

module edge_trigger_with_cooldown
    import etc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // item channel
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire in_item_t          item,
    // result channel
    output logic                   result_valid,
    input  wire logic              result_ready,
    output out_item_t              result,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cfg_t      cfg;
    st_t       st_reg;
    st_t       st_next;
    out_item_t res;

    // input register
    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;

    // result register
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;

    logic      in_xfer;
    logic      adv;

    assign pready = 1'b1;

    etc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    etc_eval u_eval (
        .cfg     (cfg),
        .st      (st_reg),
        .item    (in_item_reg),
        .st_next (st_next),
        .res     (res)
    );

    // the held item moves on when the result register is free or draining
    assign adv        = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || adv;
    assign in_xfer    = item_valid && item_ready;

    assign in_valid_next  = in_xfer || (in_valid_reg && !adv);
    assign out_valid_next = adv || (out_valid_reg && !result_ready);

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // control and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            st_reg.cooldown_left     <= 16'd0;
            st_reg.fire_latch        <= 1'b0;
            st_reg.sent_symbol       <= 8'd0;
            st_reg.sent_symbol_valid <= 1'b0;
            st_reg.held_level        <= 14'd0;
            st_reg.low_mark          <= FULL_SCALE;
            st_reg.pending_low       <= FULL_SCALE;
            st_reg.pending_active    <= 1'b0;
            st_reg.pending_age       <= 16'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                st_reg <= st_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg <= item;
        end
        if (adv)
        begin
            out_item_reg <= res;
        end
    end

    // a fire always leaves the latch set
    `ETC_ASSERT(a_fire_sets_latch, clk, rst_n,
        adv && res.fired |=> st_reg.fire_latch, "fire without latch")
    // a fire loads the full cooldown
    `ETC_ASSERT(a_fire_loads_cooldown, clk, rst_n,
        adv && res.fired |=> st_reg.cooldown_left == $past(cfg.cooldown_ms),
        "cooldown not loaded on fire")
    // an item held in cooldown never fires
    `ETC_ASSERT_NEVER(a_no_fire_when_held, clk, rst_n,
        out_valid_reg && out_item_reg.fired && out_item_reg.status != ST_EVAL,
        "fire outside evaluation")
    // grace timer only runs on an active pending low
    `ETC_ASSERT_NEVER(a_age_needs_pending, clk, rst_n,
        !st_reg.pending_active && st_reg.pending_age != 16'd0,
        "pending age without pending low")
    // watermark never above full scale
    `ETC_ASSERT_NEVER(a_mark_in_range, clk, rst_n,
        st_reg.low_mark > FULL_SCALE, "low watermark above full scale")

endmodule

`default_nettype wire

/* design/etc_regs.sv */
`default_nettype none

module etc_regs
    import etc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_DETECT_MODE: cfg_next.detect_mode = mode_t'(pwdata[0]);
                REG_THRESHOLD:   cfg_next.threshold   = pwdata[13:0];
                REG_FIRE_ABOVE:  cfg_next.fire_above  = pwdata[0];
                REG_COOLDOWN_MS: cfg_next.cooldown_ms = pwdata[15:0];
                REG_WM_ENABLE:   cfg_next.wm_enable   = pwdata[0];
                REG_GRACE_MS:    cfg_next.grace_ms    = pwdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DETECT_MODE: prdata = {31'd0, cfg_reg.detect_mode};
            REG_THRESHOLD:   prdata = {18'd0, cfg_reg.threshold};
            REG_FIRE_ABOVE:  prdata = {31'd0, cfg_reg.fire_above};
            REG_COOLDOWN_MS: prdata = {16'd0, cfg_reg.cooldown_ms};
            REG_WM_ENABLE:   prdata = {31'd0, cfg_reg.wm_enable};
            REG_GRACE_MS:    prdata = {16'd0, cfg_reg.grace_ms};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_mode <= MODE_LEVEL;
            cfg_reg.threshold   <= THRESHOLD_RST;
            cfg_reg.fire_above  <= 1'b1;
            cfg_reg.cooldown_ms <= COOLDOWN_RST;
            cfg_reg.wm_enable   <= 1'b0;
            cfg_reg.grace_ms    <= GRACE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* design/etc_eval.sv */
`default_nettype none

module etc_eval
    import etc_pkg::*;
(
    input  wire cfg_t      cfg,
    input  wire st_t       st,
    input  wire in_item_t  item,
    output st_t            st_next,
    output out_item_t      res
);

    logic [13:0] lvl;
    logic [13:0] lm0;
    logic [13:0] pl0;
    logic        pa0;
    logic [15:0] age0;
    logic [16:0] age_sum;
    logic [15:0] age1;
    logic [15:0] cd1;
    logic        held;
    logic [13:0] wm_v;
    logic        cond;
    logic        confident;

    always_comb
    begin
        lvl = (item.level > FULL_SCALE) ? FULL_SCALE : item.level;

        // watermark clear comes first
        lm0  = item.clear_watermark ? FULL_SCALE : st.low_mark;
        pl0  = item.clear_watermark ? FULL_SCALE : st.pending_low;
        pa0  = item.clear_watermark ? 1'b0 : st.pending_active;
        age0 = item.clear_watermark ? 16'd0 : st.pending_age;

        // pending age runs on every item while a low is pending, saturating
        age_sum = {1'b0, age0} + {1'b0, item.elapsed_ms};
        age1    = pa0 ? (age_sum[16] ? 16'hFFFF : age_sum[15:0]) : age0;

        cd1  = (st.cooldown_left > item.elapsed_ms) ?
               (st.cooldown_left - item.elapsed_ms) : 16'd0;
        held = (cd1 != 16'd0);

        st_next                = st;
        st_next.low_mark       = lm0;
        st_next.pending_low    = pl0;
        st_next.pending_active = pa0;
        st_next.pending_age    = age1;
        st_next.cooldown_left  = cd1;

        res.fired           = 1'b0;
        res.reported_level  = st.held_level;
        res.reported_symbol = st.sent_symbol;
        res.status          = ST_HELD;

        cond      = 1'b0;
        confident = 1'b0;
        wm_v      = lvl;

        if (held)
        begin
            res.status = ST_HELD;
        end
        else if (!item.measure_ok)
        begin
            res.status         = ST_ERROR;
            st_next.held_level = 14'd0;
            res.reported_level = 14'd0;
        end
        else
        begin
            res.status = ST_EVAL;
            if (cfg.detect_mode == MODE_LEVEL && cfg.wm_enable)
            begin
                if (lvl >= lm0)
                begin
                    st_next.pending_low    = lm0;
                    st_next.pending_active = 1'b0;
                    st_next.pending_age    = 16'd0;
                end
                else
                begin
                    // a new or deeper low restarts the grace timer
                    if (!pa0 || lvl < pl0)
                    begin
                        st_next.pending_low    = lvl;
                        st_next.pending_active = 1'b1;
                        st_next.pending_age    = 16'd0;
                    end
                    if (st_next.pending_age >= cfg.grace_ms)
                    begin
                        st_next.low_mark       = st_next.pending_low;
                        st_next.pending_active = 1'b0;
                        st_next.pending_age    = 16'd0;
                    end
                end
                wm_v = st_next.low_mark;
            end
            st_next.held_level = wm_v;
            res.reported_level = wm_v;

            if (cfg.detect_mode == MODE_LEVEL)
            begin
                cond = cfg.fire_above ? (wm_v > cfg.threshold) : (wm_v < cfg.threshold);
                if (cond && !st.fire_latch)
                begin
                    st_next.fire_latch    = 1'b1;
                    st_next.cooldown_left = cfg.cooldown_ms;
                    res.fired             = 1'b1;
                end
                else if (!cond)
                begin
                    st_next.fire_latch = 1'b0;
                end
            end
            else
            begin
                confident = (wm_v >= cfg.threshold) &&
                            ({9'd0, item.symbol_index} < 17'(SYMBOL_COUNT));
                if (confident && (!st.sent_symbol_valid ||
                                  item.symbol_index != st.sent_symbol))
                begin
                    st_next.sent_symbol       = item.symbol_index;
                    st_next.sent_symbol_valid = 1'b1;
                    st_next.cooldown_left     = cfg.cooldown_ms;
                    st_next.fire_latch        = 1'b1;
                    res.fired                 = 1'b1;
                end
                else if (!confident)
                begin
                    st_next.fire_latch        = 1'b0;
                    st_next.sent_symbol_valid = 1'b0;
                end
                res.reported_symbol = item.symbol_index;
            end
        end

        res.latched               = st_next.fire_latch;
        res.reported_symbol_valid = st_next.sent_symbol_valid;
        res.cooldown_left_ms      = st_next.cooldown_left;
    end

endmodule

`default_nettype wire
